@@ rtl/pcts_pkg.sv @@
// Package: shared constants, codes and result type of the per-channel time-sorting buffer.
package pcts_pkg;

   // Default sizes of the store.
   localparam int CHANNELS_DEFAULT  = 16;
   localparam int ENTRIES_DEFAULT   = 256;
   localparam int TIME_BITS_DEFAULT = 48;

   // Fixed widths of the transfer fields.
   localparam int KIND_W    = 2;
   localparam int CHANNEL_W = 8;
   localparam int STAMP_W   = 48;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 9;
   localparam int ORDER_W   = 32;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP        = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_BEFORE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HEAD_LATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // One result as held in the output register.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 item_valid;
      logic [STAMP_W-1:0]   item_time;
      logic [PAYLOAD_W-1:0] item_payload;
      logic [COUNT_W-1:0]   channel_count;
      logic [STAMP_W-1:0]   first_time;
      logic [STAMP_W-1:0]   last_time;
   } rsp_type;

endpackage

@@ rtl/pcts_if.sv @@
// Interfaces: request and response channels with valid/ready handshake.
interface pcts_req_if;
   import pcts_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [CHANNEL_W-1:0] channel;
   logic [STAMP_W-1:0]   stamp;
   logic [PAYLOAD_W-1:0] payload;
   modport source (output valid, kind, channel, stamp, payload, input ready);
   modport sink (input valid, kind, channel, stamp, payload, output ready);
endinterface

interface pcts_rsp_if;
   import pcts_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 item_valid;
   logic [STAMP_W-1:0]   item_time;
   logic [PAYLOAD_W-1:0] item_payload;
   logic [COUNT_W-1:0]   channel_count;
   logic [STAMP_W-1:0]   first_time;
   logic [STAMP_W-1:0]   last_time;
   modport source (output valid, status, item_valid, item_time, item_payload,
                   channel_count, first_time, last_time, input ready);
   modport sink (input valid, status, item_valid, item_time, item_payload,
                 channel_count, first_time, last_time, output ready);
endinterface

@@ rtl/per_channel_time_sorting_buffer_top.sv @@
// Per-channel time-sorting buffer: a binary min-heap per channel in one shared memory.
// A rejected or undefined request goes straight to the result; an insert walks the new entry up
// from the end of the heap, and a pop moves the last entry to the root, walks it down and reads
// the new root back for the earliest time; popping the last entry goes straight to the result.
// One request at a time: the next is taken in the cycle after the result is loaded, and a stalled
// result holds the block. Synchronous active-high reset empties every channel and the counter.
module per_channel_time_sorting_buffer_top #(
   parameter int CHANNELS            = pcts_pkg::CHANNELS_DEFAULT,
   parameter int ENTRIES_PER_CHANNEL = pcts_pkg::ENTRIES_DEFAULT,
   parameter int TIME_BITS           = pcts_pkg::TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pcts_req_if.sink   req,
   pcts_rsp_if.source rsp
);
   import pcts_pkg::*;

   localparam int IDX_BITS  = $clog2(ENTRIES_PER_CHANNEL);
   localparam int IW        = IDX_BITS + 1;
   localparam int CNT_BITS  = $clog2(ENTRIES_PER_CHANNEL + 1);
   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_BITS = CH_BITS + IDX_BITS;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_DECODE   = 15'b000000000000010,
      S_UP_RD    = 15'b000000000000100,
      S_UP_CMP   = 15'b000000000001000,
      S_POP_RD   = 15'b000000000010000,
      S_POP_LAST = 15'b000000000100000,
      S_POP_MOV  = 15'b000000001000000,
      S_DN_L     = 15'b000000010000000,
      S_DN_R     = 15'b000000100000000,
      S_DN_RC    = 15'b000001000000000,
      S_DN_C     = 15'b000010000000000,
      S_WRITE    = 15'b000100000000000,
      S_ROOT_RD  = 15'b001000000000000,
      S_ROOT_GET = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [CHANNEL_W-1:0] chan_ff, chan_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic [PAYLOAD_W-1:0] pay_ff, pay_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]  pos_ff, pos_in;
   logic [TIME_BITS-1:0] mov_time_ff, mov_time_in;
   logic [ORDER_W-1:0]   mov_order_ff, mov_order_in;
   logic [PAYLOAD_W-1:0] mov_pay_ff, mov_pay_in;
   logic [TIME_BITS-1:0] kid_time_ff, kid_time_in;
   logic [ORDER_W-1:0]   kid_order_ff, kid_order_in;
   logic [PAYLOAD_W-1:0] kid_pay_ff, kid_pay_in;
   logic [IDX_BITS-1:0]  kid_idx_ff, kid_idx_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 ivalid_ff, ivalid_in;
   logic [TIME_BITS-1:0] itime_ff, itime_in;
   logic [PAYLOAD_W-1:0] ipay_ff, ipay_in;
   logic [ORDER_W-1:0]   seq_ff, seq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Per-channel bookkeeping.
   logic [CNT_BITS-1:0]  fill_ff  [CHANNELS];
   logic [TIME_BITS-1:0] first_ff [CHANNELS];
   logic [TIME_BITS-1:0] last_ff  [CHANNELS];
   logic                 fill_we, first_we, last_we;
   logic [CNT_BITS-1:0]  fill_val;
   logic [TIME_BITS-1:0] first_val, last_val;

   // Memory and comparator connections.
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx, rd_idx;
   logic [TIME_BITS-1:0] wr_time, rd_time;
   logic [ORDER_W-1:0]   wr_order, rd_order;
   logic [PAYLOAD_W-1:0] wr_payload, rd_payload;
   logic [TIME_BITS-1:0] cmp_a_time, cmp_b_time;
   logic [ORDER_W-1:0]   cmp_a_order, cmp_b_order;
   logic                 cmp_less;

   logic [CH_BITS-1:0]   ch_idx;
   logic                 ch_legal;
   logic [CNT_BITS-1:0]  ch_fill;
   logic [IDX_BITS-1:0]  parent_idx;
   logic [IW-1:0]        left_wide, right_wide, cnt_wide;

   assign ch_idx     = chan_ff[CH_BITS-1:0];
   assign ch_legal   = (chan_ff < CHANNEL_W'(CHANNELS));
   assign ch_fill    = fill_ff[ch_idx];
   assign parent_idx = IDX_BITS'((pos_ff - 1'b1) >> 1);
   assign left_wide  = {pos_ff, 1'b1};
   assign right_wide = IW'(kid_idx_ff) + 1'b1;
   assign cnt_wide   = IW'(cnt_ff);

   pcts_store #(
      .ADDR_BITS (ADDR_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    ({ch_idx, wr_idx}),
      .wr_time    (wr_time),
      .wr_order   (wr_order),
      .wr_payload (wr_payload),
      .rd_addr    ({ch_idx, rd_idx}),
      .rd_time    (rd_time),
      .rd_order   (rd_order),
      .rd_payload (rd_payload)
   );

   pcts_cmp #(
      .TIME_BITS (TIME_BITS)
   ) u_cmp (
      .a_time  (cmp_a_time),
      .a_order (cmp_a_order),
      .b_time  (cmp_b_time),
      .b_order (cmp_b_order),
      .a_less  (cmp_less)
   );

   // Comparator operand selection.
   always_comb begin
      cmp_a_time  = kid_time_ff;
      cmp_a_order = kid_order_ff;
      cmp_b_time  = mov_time_ff;
      cmp_b_order = mov_order_ff;
      if (state_ff == S_UP_CMP) begin
         cmp_a_time  = mov_time_ff;
         cmp_a_order = mov_order_ff;
         cmp_b_time  = rd_time;
         cmp_b_order = rd_order;
      end else if (state_ff == S_DN_RC) begin
         cmp_a_time  = rd_time;
         cmp_a_order = rd_order;
         cmp_b_time  = kid_time_ff;
         cmp_b_order = kid_order_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      chan_in      = chan_ff;
      stamp_in     = stamp_ff;
      pay_in       = pay_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      mov_time_in  = mov_time_ff;
      mov_order_in = mov_order_ff;
      mov_pay_in   = mov_pay_ff;
      kid_time_in  = kid_time_ff;
      kid_order_in = kid_order_ff;
      kid_pay_in   = kid_pay_ff;
      kid_idx_in   = kid_idx_ff;
      status_in    = status_ff;
      ivalid_in    = ivalid_ff;
      itime_in     = itime_ff;
      ipay_in      = ipay_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fill_we      = 1'b0;
      first_we     = 1'b0;
      last_we      = 1'b0;
      fill_val     = cnt_ff;
      first_val    = mov_time_ff;
      last_val     = mov_time_ff;
      wr_en        = 1'b0;
      wr_idx       = pos_ff;
      wr_time      = mov_time_ff;
      wr_order     = mov_order_ff;
      wr_payload   = mov_pay_ff;
      rd_idx       = '0;

      // The output register empties on a completed transfer.
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               kind_in  = req.kind;
               chan_in  = req.channel;
               stamp_in = TIME_BITS'(req.stamp);
               pay_in   = req.payload;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            ivalid_in = 1'b0;
            itime_in  = '0;
            ipay_in   = '0;
            cnt_in    = ch_fill;
            state_in  = S_DONE;
            if (!ch_legal) begin
               status_in = ST_ILLEGAL;
            end else if (kind_ff == KIND_INSERT) begin
               if (ch_fill == CNT_BITS'(ENTRIES_PER_CHANNEL)) begin
                  status_in = ST_FULL;
               end else begin
                  mov_time_in  = stamp_ff;
                  mov_order_in = seq_ff;
                  mov_pay_in   = pay_ff;
                  seq_in       = seq_ff + 1'b1;
                  pos_in       = IDX_BITS'(ch_fill);
                  state_in     = S_UP_RD;
               end
            end else if (kind_ff == KIND_POP || kind_ff == KIND_POP_BEFORE) begin
               if (ch_fill == '0) begin
                  status_in = ST_EMPTY;
               end else if (kind_ff == KIND_POP_BEFORE && !(first_ff[ch_idx] < stamp_ff)) begin
                  status_in = ST_HEAD_LATE;
               end else begin
                  state_in = S_POP_RD;
               end
            end
         end
         S_UP_RD: begin
            rd_idx = parent_idx;
            state_in = (pos_ff == '0) ? S_WRITE : S_UP_CMP;
         end
         S_UP_CMP: begin
            // Move the later parent down one level, or stop here.
            if (cmp_less) begin
               wr_en      = 1'b1;
               wr_time    = rd_time;
               wr_order   = rd_order;
               wr_payload = rd_payload;
               pos_in     = parent_idx;
               state_in   = S_UP_RD;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_POP_RD: begin
            rd_idx   = '0;
            state_in = S_POP_LAST;
         end
         S_POP_LAST: begin
            ivalid_in = 1'b1;
            itime_in  = rd_time;
            ipay_in   = rd_payload;
            cnt_in    = CNT_BITS'(cnt_ff - 1'b1);
            rd_idx    = IDX_BITS'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_BITS'(1)) begin
               fill_we  = 1'b1;
               fill_val = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_POP_MOV;
            end
         end
         S_POP_MOV: begin
            mov_time_in  = rd_time;
            mov_order_in = rd_order;
            mov_pay_in   = rd_payload;
            pos_in       = '0;
            state_in     = S_DN_L;
         end
         S_DN_L: begin
            rd_idx     = IDX_BITS'(left_wide);
            kid_idx_in = IDX_BITS'(left_wide);
            state_in   = (left_wide >= cnt_wide) ? S_WRITE : S_DN_R;
         end
         S_DN_R: begin
            kid_time_in  = rd_time;
            kid_order_in = rd_order;
            kid_pay_in   = rd_payload;
            rd_idx       = IDX_BITS'(right_wide);
            state_in     = (right_wide < cnt_wide) ? S_DN_RC : S_DN_C;
         end
         S_DN_RC: begin
            // Keep the earlier of the two children.
            if (cmp_less) begin
               kid_time_in  = rd_time;
               kid_order_in = rd_order;
               kid_pay_in   = rd_payload;
               kid_idx_in   = IDX_BITS'(right_wide);
            end
            state_in = S_DN_C;
         end
         S_DN_C: begin
            if (cmp_less) begin
               wr_en      = 1'b1;
               wr_time    = kid_time_ff;
               wr_order   = kid_order_ff;
               wr_payload = kid_pay_ff;
               pos_in     = kid_idx_ff;
               state_in   = S_DN_L;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en = 1'b1;
            if (kind_ff == KIND_INSERT) begin
               // Earliest and latest times follow directly from the new stamp.
               fill_we   = 1'b1;
               fill_val  = CNT_BITS'(cnt_ff + 1'b1);
               first_we  = 1'b1;
               last_we   = 1'b1;
               first_val = (cnt_ff == '0 || mov_time_ff < first_ff[ch_idx]) ?
                           mov_time_ff : first_ff[ch_idx];
               last_val  = (cnt_ff == '0 || mov_time_ff >= last_ff[ch_idx]) ?
                           mov_time_ff : last_ff[ch_idx];
               state_in  = S_DONE;
            end else begin
               state_in = S_ROOT_RD;
            end
         end
         S_ROOT_RD: begin
            rd_idx   = '0;
            state_in = S_ROOT_GET;
         end
         S_ROOT_GET: begin
            fill_we   = 1'b1;
            fill_val  = cnt_ff;
            first_we  = 1'b1;
            first_val = rd_time;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.item_valid   = ivalid_ff;
               rsp_data_in.item_time    = STAMP_W'(itime_ff);
               rsp_data_in.item_payload = ipay_ff;
               rsp_data_in.channel_count = '0;
               rsp_data_in.first_time   = '0;
               rsp_data_in.last_time    = '0;
               if (ch_legal) begin
                  rsp_data_in.channel_count = COUNT_W'(ch_fill);
                  if (ch_fill != '0) begin
                     rsp_data_in.first_time = STAMP_W'(first_ff[ch_idx]);
                     rsp_data_in.last_time  = STAMP_W'(last_ff[ch_idx]);
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      chan_ff      <= chan_in;
      stamp_ff     <= stamp_in;
      pay_ff       <= pay_in;
      cnt_ff       <= cnt_in;
      pos_ff       <= pos_in;
      mov_time_ff  <= mov_time_in;
      mov_order_ff <= mov_order_in;
      mov_pay_ff   <= mov_pay_in;
      kid_time_ff  <= kid_time_in;
      kid_order_ff <= kid_order_in;
      kid_pay_ff   <= kid_pay_in;
      kid_idx_ff   <= kid_idx_in;
      status_ff    <= status_in;
      ivalid_ff    <= ivalid_in;
      itime_ff     <= itime_in;
      ipay_ff      <= ipay_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Channel counts; reset empties every channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (fill_we) begin
         fill_ff[ch_idx] <= fill_val;
      end
   end

   // Earliest and latest times, only read while the channel holds entries.
   always_ff @(posedge clock) begin
      if (first_we) begin
         first_ff[ch_idx] <= first_val;
      end
      if (last_we) begin
         last_ff[ch_idx] <= last_val;
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_data_ff.status;
   assign rsp.item_valid    = rsp_data_ff.item_valid;
   assign rsp.item_time     = rsp_data_ff.item_time;
   assign rsp.item_payload  = rsp_data_ff.item_payload;
   assign rsp.channel_count = rsp_data_ff.channel_count;
   assign rsp.first_time    = rsp_data_ff.first_time;
   assign rsp.last_time     = rsp_data_ff.last_time;

endmodule

@@ rtl/pcts_store.sv @@
// Entry memory: one write port and one registered read port holding time, order and handle.
module pcts_store #(
   parameter int ADDR_BITS = 12,
   parameter int TIME_BITS = 48
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_BITS-1:0]               wr_addr,
   input  logic [TIME_BITS-1:0]               wr_time,
   input  logic [pcts_pkg::ORDER_W-1:0]       wr_order,
   input  logic [pcts_pkg::PAYLOAD_W-1:0]     wr_payload,
   input  logic [ADDR_BITS-1:0]               rd_addr,
   output logic [TIME_BITS-1:0]               rd_time,
   output logic [pcts_pkg::ORDER_W-1:0]       rd_order,
   output logic [pcts_pkg::PAYLOAD_W-1:0]     rd_payload
);
   import pcts_pkg::*;

   localparam int DEPTH  = 2 ** ADDR_BITS;
   localparam int WORD_W = TIME_BITS + ORDER_W + PAYLOAD_W;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_time, wr_order, wr_payload};
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_time    = rd_word_ff[WORD_W-1 -: TIME_BITS];
   assign rd_order   = rd_word_ff[PAYLOAD_W +: ORDER_W];
   assign rd_payload = rd_word_ff[PAYLOAD_W-1:0];

endmodule

@@ rtl/pcts_cmp.sv @@
// Shared key comparator: earlier time first, equal times in arrival order.
module pcts_cmp #(
   parameter int TIME_BITS = 48
) (
   input  logic [TIME_BITS-1:0]         a_time,
   input  logic [pcts_pkg::ORDER_W-1:0] a_order,
   input  logic [TIME_BITS-1:0]         b_time,
   input  logic [pcts_pkg::ORDER_W-1:0] b_order,
   output logic                         a_less
);
   import pcts_pkg::*;

   logic [ORDER_W-1:0] order_diff;

   // Arrival order is compared by wrapped difference so the counter may roll over.
   assign order_diff = a_order - b_order;
   assign a_less = (a_time < b_time) ||
                   ((a_time == b_time) && order_diff[ORDER_W-1]);

endmodule

@@ rtl/pcts_checker.sv @@
// Checker: port-level properties of the per-channel time-sorting buffer, bound to the top level.
module pcts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pcts_pkg::STATUS_W-1:0]  rsp_status,
   input logic                           rsp_item_valid,
   input logic [pcts_pkg::COUNT_W-1:0]   rsp_channel_count,
   input logic [pcts_pkg::STAMP_W-1:0]   rsp_first_time,
   input logic [pcts_pkg::STAMP_W-1:0]   rsp_last_time
);
   import pcts_pkg::*;

   // A stalled result stays valid and holds its status and channel count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_channel_count))
      else $error("stalled result changed");

   // One request at a time: after a transfer in, the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A returned entry only comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_valid |-> rsp_status == ST_OK)
      else $error("entry returned with error status");

   // An illegal channel reports no entry and a zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ILLEGAL |-> !rsp_item_valid && rsp_channel_count == '0)
      else $error("illegal channel reported data");

   // An empty channel reports zero times.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_count == '0 |-> rsp_first_time == '0 && rsp_last_time == '0)
      else $error("empty channel reported times");

endmodule

bind per_channel_time_sorting_buffer_top pcts_checker u_pcts_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_item_valid    (rsp.item_valid),
   .rsp_channel_count (rsp.channel_count),
   .rsp_first_time    (rsp.first_time),
   .rsp_last_time     (rsp.last_time)
);
